// ===== hw/rtl/cau_pkg.sv =====
`default_nettype none

package cau_pkg;

	// quotient bits resolved by the divider pipe, one per stage
	localparam int QUO_BITS = 33;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_CONJ = 3'd4
	} op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic [1:0]  status;
	} res_t;

	// one part of a quotient under way
	typedef struct packed {
		logic                neg;
		logic                ovf;
		logic [63:0]         rem;
		logic [QUO_BITS-1:0] nlo;
		logic [QUO_BITS-1:0] quo;
	} dpart_t;

	typedef struct packed {
		logic        is_div;
		res_t        early;
		logic [63:0] den;
		dpart_t      re;
		dpart_t      im;
	} dstage_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cau_prep.sv =====
`default_nettype none

module cau_prep import cau_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               ce,
	input  wire logic               in_valid,
	input  wire logic [2:0]         op,
	input  wire logic signed [31:0] a_re,
	input  wire logic signed [31:0] a_im,
	input  wire logic signed [31:0] b_re,
	input  wire logic signed [31:0] b_im,
	output logic                    out_valid,
	output dstage_t                 out_data
);

	localparam int NUM_W = 64 + FRAC_BITS;

	function automatic logic [32:0] sat_33(input logic signed [32:0] v);
		logic sat;
		sat = v[32] ^ v[31];
		return {sat, sat ? (v[32] ? SAT_NEG : SAT_POS) : v[31:0]};
	endfunction

	function automatic logic [32:0] sat_wide(input logic signed [64:0] v);
		logic sat;
		sat = !((&v[64:31]) || !(|v[64:31]));
		return {sat, sat ? (v[64] ? SAT_NEG : SAT_POS) : v[31:0]};
	endfunction

	function automatic dpart_t div_init(input logic neg, input logic [63:0] mag,
			input logic [63:0] den);
		logic [NUM_W-1:0] num;
		logic [63:0]      hi;
		dpart_t           p;
		num   = NUM_W'(mag) << FRAC_BITS;
		hi    = 64'(num[NUM_W-1:QUO_BITS]);
		p.neg = neg;
		// quotient needs more than QUO_BITS bits: saturates regardless
		p.ovf = hi >= den;
		p.rem = p.ovf ? '0 : hi;
		p.nlo = num[QUO_BITS-1:0];
		p.quo = '0;
		return p;
	endfunction

	// stage 1: products and the short add/sub/conjugate
	logic signed [32:0] smp_re, smp_im;
	always_comb begin
		smp_re = '0;
		smp_im = '0;
		case (op)
			OP_ADD: begin
				smp_re = 33'(a_re) + 33'(b_re);
				smp_im = 33'(a_im) + 33'(b_im);
			end
			OP_SUB: begin
				smp_re = 33'(a_re) - 33'(b_re);
				smp_im = 33'(a_im) - 33'(b_im);
			end
			OP_CONJ: begin
				smp_re = 33'(a_re);
				smp_im = -33'(a_im);
			end
			default: begin
			end
		endcase
	end

	logic               v_s1;
	logic [2:0]         op_s1;
	logic signed [63:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_br2_s1, p_bi2_s1;
	logic signed [32:0] smp_re_s1, smp_im_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			op_s1     <= op;
			p_rr_s1   <= a_re * b_re;
			p_ii_s1   <= a_im * b_im;
			p_ri_s1   <= a_re * b_im;
			p_ir_s1   <= a_im * b_re;
			p_br2_s1  <= b_re * b_re;
			p_bi2_s1  <= b_im * b_im;
			smp_re_s1 <= smp_re;
			smp_im_s1 <= smp_im;
		end
	end

	// stage 2: cross sums and squared magnitude of b
	logic signed [64:0] sum_re, sum_im;
	logic [63:0]        den;
	always_comb begin
		if (op_s1 == OP_DIV) begin
			sum_re = 65'(p_rr_s1) + 65'(p_ii_s1);
			sum_im = 65'(p_ir_s1) - 65'(p_ri_s1);
		end else begin
			sum_re = 65'(p_rr_s1) - 65'(p_ii_s1);
			sum_im = 65'(p_ri_s1) + 65'(p_ir_s1);
		end
		den = p_br2_s1[63:0] + p_bi2_s1[63:0];
	end

	logic               v_s2;
	logic [2:0]         op_s2;
	logic signed [64:0] sum_re_s2, sum_im_s2;
	logic [63:0]        den_s2;
	logic signed [32:0] smp_re_s2, smp_im_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ce) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			op_s2     <= op_s1;
			sum_re_s2 <= sum_re;
			sum_im_s2 <= sum_im;
			den_s2    <= den;
			smp_re_s2 <= smp_re_s1;
			smp_im_s2 <= smp_im_s1;
		end
	end

	// stage 3: final result of the short ops and of the multiply, magnitudes for the divider
	logic [32:0] pk_re, pk_im;
	res_t        early;
	logic        is_div;
	logic [63:0] mag_re, mag_im;
	always_comb begin
		pk_re  = '0;
		pk_im  = '0;
		is_div = 1'b0;
		case (op_s2)
			OP_ADD, OP_SUB, OP_CONJ: begin
				pk_re = sat_33(smp_re_s2);
				pk_im = sat_33(smp_im_s2);
			end
			OP_MUL: begin
				pk_re = sat_wide(sum_re_s2 >>> FRAC_BITS);
				pk_im = sat_wide(sum_im_s2 >>> FRAC_BITS);
			end
			OP_DIV: begin
				is_div = den_s2 != '0;
			end
			default: begin
			end
		endcase
		early.re     = pk_re[31:0];
		early.im     = pk_im[31:0];
		early.status = (pk_re[32] || pk_im[32]) ? ST_SAT : ST_OK;
		if (op_s2 == OP_DIV && den_s2 == '0) early.status = ST_DIVZ;
		mag_re = sum_re_s2[64] ? 64'(-sum_re_s2) : sum_re_s2[63:0];
		mag_im = sum_im_s2[64] ? 64'(-sum_im_s2) : sum_im_s2[63:0];
	end

	logic        v_s3;
	logic        is_div_s3;
	res_t        early_s3;
	logic [63:0] den_s3, mag_re_s3, mag_im_s3;
	logic        neg_re_s3, neg_im_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			is_div_s3 <= is_div;
			early_s3  <= early;
			den_s3    <= den_s2;
			mag_re_s3 <= mag_re;
			mag_im_s3 <= mag_im;
			neg_re_s3 <= sum_re_s2[64];
			neg_im_s3 <= sum_im_s2[64];
		end
	end

	// stage 4: overflow check and first partial remainder
	dstage_t nxt_s4;
	always_comb begin
		nxt_s4.is_div = is_div_s3;
		nxt_s4.early  = early_s3;
		nxt_s4.den    = den_s3;
		nxt_s4.re     = div_init(neg_re_s3, mag_re_s3, den_s3);
		nxt_s4.im     = div_init(neg_im_s3, mag_im_s3, den_s3);
	end

	logic    v_s4;
	dstage_t d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ce) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			d_s4 <= nxt_s4;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = d_s4;

endmodule

`default_nettype wire

// ===== hw/rtl/cau_div_step.sv =====
`default_nettype none

module cau_div_step import cau_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    ce,
	input  wire logic    in_valid,
	input  wire dstage_t in_data,
	output logic         out_valid,
	output dstage_t      out_data
);

	// one restoring step: shift in the next numerator bit, subtract if it fits
	function automatic dpart_t div_bit(input dpart_t p, input logic [63:0] den);
		logic [64:0] t;
		logic [64:0] diff;
		logic        ge;
		dpart_t      n;
		t      = {p.rem, p.nlo[QUO_BITS-1]};
		diff   = t - {1'b0, den};
		ge     = t >= {1'b0, den};
		n      = p;
		n.rem  = ge ? diff[63:0] : t[63:0];
		n.nlo  = p.nlo << 1;
		n.quo  = {p.quo[QUO_BITS-2:0], ge};
		return n;
	endfunction

	dstage_t nxt;
	always_comb begin
		nxt    = in_data;
		nxt.re = div_bit(in_data.re, in_data.den);
		nxt.im = div_bit(in_data.im, in_data.den);
	end

	logic    v_s1;
	dstage_t d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			d_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = d_s1;

endmodule

`default_nettype wire

// ===== hw/rtl/complex_arithmetic_unit.sv =====
`default_nettype none

// channel | signals                                  | direction
// input   | in_valid, in_ready, op, a_re..b_im       | item in
// output  | out_valid, out_ready, res_re, res_im,    | result out
//         | status                                   |
//
// every op takes the same path: products, sums and magnitudes in the prep
// stages, the divider (one quotient bit per stage), then 1 output register.
// one transaction per cycle in and out while the output is not stalled.
// reset clears the valid bits only; data registers are not reset.
// a result held at the output and not taken freezes the whole pipe.

module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         op,
	input  wire logic signed [31:0] a_re,
	input  wire logic signed [31:0] a_im,
	input  wire logic signed [31:0] b_re,
	input  wire logic signed [31:0] b_im,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      res_re,
	output logic signed [31:0]      res_im,
	output logic [1:0]              status
);

	function automatic logic [32:0] pack_quo(input dpart_t p);
		logic                sat;
		logic [QUO_BITS-1:0] ng;
		logic [31:0]         v;
		ng = -p.quo;
		if (p.neg) begin
			sat = p.ovf || (p.quo > QUO_BITS'(SAT_NEG));
			v   = sat ? SAT_NEG : ng[31:0];
		end else begin
			sat = p.ovf || (p.quo[QUO_BITS-1:31] != '0);
			v   = sat ? SAT_POS : p.quo[31:0];
		end
		return {sat, v};
	endfunction

	logic ce;
	assign ce       = !out_valid || out_ready;
	assign in_ready = ce;

	logic [QUO_BITS:0] chain_valid;
	dstage_t           chain_data [QUO_BITS+1];

	cau_prep #(
		.FRAC_BITS(FRAC_BITS)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (in_valid),
		.op       (op),
		.a_re     (a_re),
		.a_im     (a_im),
		.b_re     (b_re),
		.b_im     (b_im),
		.out_valid(chain_valid[0]),
		.out_data (chain_data[0])
	);

	for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
		cau_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.ce       (ce),
			.in_valid (chain_valid[i]),
			.in_data  (chain_data[i]),
			.out_valid(chain_valid[i+1]),
			.out_data (chain_data[i+1])
		);
	end

	dstage_t     last;
	logic [32:0] q_re, q_im;
	res_t        fin;
	always_comb begin
		last = chain_data[QUO_BITS];
		q_re = pack_quo(last.re);
		q_im = pack_quo(last.im);
		if (last.is_div) begin
			fin.re     = q_re[31:0];
			fin.im     = q_im[31:0];
			fin.status = (q_re[32] || q_im[32]) ? ST_SAT : ST_OK;
		end else begin
			fin = last.early;
		end
	end

	logic        out_valid_q;
	logic [31:0] res_re_q, res_im_q;
	logic [1:0]  status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ce) begin
			out_valid_q <= chain_valid[QUO_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			res_re_q <= fin.re;
			res_im_q <= fin.im;
			status_q <= fin.status;
		end
	end

	assign out_valid = out_valid_q;
	assign res_re    = res_re_q;
	assign res_im    = res_im_q;
	assign status    = status_q;

	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DIVZ |-> res_re == '0 && res_im == '0)
		else $error("divide by zero transaction with nonzero result");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SAT |->
			res_re == SAT_POS || res_re == SAT_NEG ||
			res_im == SAT_POS || res_im == SAT_NEG)
		else $error("saturation flagged without a limit value");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output is free");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

endmodule

`default_nettype wire
